// ===== src/radix2_complex_fft_defines.svh =====
// assertion macros shared by the fft rtl
// expects clk_i and rst_ni in the scope of use
`ifndef RADIX2_COMPLEX_FFT_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_DEFINES_SVH

// same-cycle implication
`define R2FFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("r2fft: same-cycle check failed");

// next-cycle implication
`define R2FFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("r2fft: next-cycle check failed");

`endif

// ===== src/r2fft_pkg.sv =====
// types, codes and helpers for the radix-2 fft
// no dependencies
package r2fft_pkg;

  localparam int unsigned MAX_LOG2_POINTS = 10;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BIN_W      = 32;
  localparam int unsigned INDEX_W    = MAX_LOG2_POINTS;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned LG_W       = 5;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_POINTS  = 2'd0,
    CFG_INVERSE_MODE = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RD_P,
    S_RD_Q,
    S_GET_B,
    S_MUL,
    S_WR_P,
    S_WR_Q
  } state_e;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic [INDEX_W-1:0]         bin_index;
  } fft_cmd_t;

  typedef struct packed {
    logic signed [BIN_W-1:0] bin_re;
    logic signed [BIN_W-1:0] bin_im;
    logic                    bin_valid;
  } fft_result_t;

  function automatic logic signed [BIN_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh0_7FFF_FFFF;
    lo = -36'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[BIN_W-1:0];
  endfunction

endpackage

// ===== src/r2fft_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module r2fft_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/radix2_complex_fft.sv =====
// radix-2 decimation-in-time fft top level: sequencer, butterfly unit, twiddle table
// depends on r2fft_pkg, r2fft_ram and radix2_complex_fft_defines.svh
//
// usage
// - command beat: start with cmd_i, taken when busy is low
//   load beat (func 0) stores the next sample at its bit-reversed address
//   read beat (func 1) holds busy for one cycle, so no new read is taken in that cycle;
//   result_valid_o pulses for one cycle, registered from the S_READ state after the beat
//   a bin out of range or before the transform ends reads zero, not valid
// - the load beat that completes a frame of N = 2^log2_points samples (log2_points
//   clamped to 1..10) starts the transform: busy stays high until it ends, each butterfly
//   running through one shared 32x17 multiplier and a single-port-read store
// - config beat: cfg_valid_i/cfg_ready_o, ready only while idle and start is low;
//   a write to log2_points or inverse mode drops the frame, other indexes are ignored
// - inverse mode divides by N with rounding during the last butterfly stage
// - reset: log2_points 10, forward mode, empty frame; store contents undefined
// - results carry no backpressure, the receiver must take each strobe
`include "radix2_complex_fft_defines.svh"
module radix2_complex_fft (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  r2fft_pkg::fft_cmd_t                  cmd_i,
  output logic                                 result_valid_o,
  output r2fft_pkg::fft_result_t               result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS;
  localparam int unsigned AW       = MAX_LOG2_POINTS;
  localparam int unsigned NPTS     = 1 << MAX_LOG2_POINTS;
  localparam int unsigned TW_DEPTH = 1 << (MAX_LOG2_POINTS - 1);
  localparam int unsigned TWA      = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;
  localparam int unsigned LG_W     = r2fft_pkg::LG_W;

  typedef logic signed [15:0] tw_arr_t [TW_DEPTH];

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tw_arr_t build_tw(input bit want_sin);
    tw_arr_t           t;
    longint unsigned   a, x2, tc, ts, dc, ds, kk, npts;
    longint            sc, ss, c0, s0, r;
    npts = longint'(1) << MAX_LOG2_POINTS;
    for (int k = 0; k < TW_DEPTH; k++) begin
      if (4 * k <= npts) begin
        kk = longint'(k);
      end else begin
        kk = longint'(k) - (npts >> 2);
      end
      a  = (64'd6746518852 * kk + (npts >> 1)) >> MAX_LOG2_POINTS;
      x2 = (a * a + 64'd536870912) >> 30;
      tc = 64'd1073741824;
      ts = a;
      sc = longint'(tc);
      ss = longint'(ts);
      for (int i = 1; i <= 10; i++) begin
        dc = longint'(2 * i - 1) * longint'(2 * i);
        ds = longint'(2 * i) * longint'(2 * i + 1);
        tc = (tc * x2 + 64'd536870912) >> 30;
        tc = div_u64(tc + (dc >> 1), dc);
        ts = (ts * x2 + 64'd536870912) >> 30;
        ts = div_u64(ts + (ds >> 1), ds);
        if (i % 2 == 1) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      if (4 * k <= npts) begin
        c0 = sc;
        s0 = ss;
      end else begin
        c0 = -ss;
        s0 = sc;
      end
      r = want_sin ? s0 : c0;
      r = (r + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      t[k] = r[15:0];
    end
    return t;
  endfunction

  localparam tw_arr_t TW_COS = build_tw(1'b0);
  localparam tw_arr_t TW_SIN = build_tw(1'b1);

  r2fft_pkg::state_e state_q, state_d;

  logic [3:0]          log2_q, log2_d;
  logic                inv_q, inv_d;
  logic [AW:0]         count_q, count_d;
  logic                done_q, done_d;
  logic [LG_W-1:0]     stage_q, stage_d;
  logic [AW-1:0]       bfly_q, bfly_d;
  logic [2:0]          mstep_q, mstep_d;
  logic                rd_ok_q, rd_ok_d;

  logic signed [31:0]  ur_q, ui_q, br_q, bi_q;
  logic signed [15:0]  wr_q;
  logic signed [16:0]  wi_q;
  logic signed [48:0]  prod_q;
  logic signed [49:0]  acc_re_q, acc_im_q;

  logic                result_valid_q;
  r2fft_pkg::fft_result_t result_q;

  logic [LG_W-1:0]     lg;
  logic [AW:0]         npts_cur;
  logic                cmd_take, cfg_take;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [63:0]         ram_wdata, ram_rdata;

  logic [AW-1:0]       rev_full, load_addr;
  logic [AW-1:0]       half_mask, p_addr, q_addr, jj;
  logic [TWA-1:0]      tw_idx;
  logic                last_bfly, last_stage;

  logic signed [31:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [34:0]  vr, vi;
  logic signed [31:0]  yp_re, yp_im, yq_re, yq_im;

  function automatic logic signed [31:0] scale_out(input logic signed [31:0] x,
                                                   input logic [LG_W-1:0] s,
                                                   input logic en);
    logic signed [32:0] t;
    if (!en) begin
      return x;
    end
    t = 33'(x) + (33'sd1 <<< (s - 1'b1));
    t = t >>> s;
    return t[31:0];
  endfunction

  always_comb begin
    if (log2_q == 4'd0) begin
      lg = LG_W'(1);
    end else if (LG_W'(log2_q) > LG_W'(MAX_LOG2_POINTS)) begin
      lg = LG_W'(MAX_LOG2_POINTS);
    end else begin
      lg = LG_W'(log2_q);
    end
  end

  assign npts_cur = (AW + 1)'(1) << lg;
  assign busy     = (state_q != r2fft_pkg::S_IDLE);
  assign cmd_take = start && !busy;
  assign cfg_ready_o = !busy && !start;
  assign cfg_take = cfg_valid_i && cfg_ready_o;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev_full[i] = count_q[AW-1-i];
    end
    load_addr = rev_full >> (LG_W'(AW) - lg);
  end

  always_comb begin
    half_mask  = (AW'(1) << (stage_q - 1'b1)) - AW'(1);
    jj         = bfly_q & half_mask;
    p_addr     = ((bfly_q >> (stage_q - 1'b1)) << stage_q) | jj;
    q_addr     = p_addr | (half_mask + AW'(1));
    tw_idx     = TWA'(jj << (LG_W'(AW) - stage_q));
    last_bfly  = ({1'b0, bfly_q} + (AW + 1)'(1)) == (npts_cur >> 1);
    last_stage = (stage_q == lg);
  end

  always_comb begin
    unique case (mstep_q)
      3'd0:    begin mul_a = br_q; mul_b = 17'(wr_q); end
      3'd1:    begin mul_a = bi_q; mul_b = wi_q;      end
      3'd2:    begin mul_a = br_q; mul_b = wi_q;      end
      3'd3:    begin mul_a = bi_q; mul_b = 17'(wr_q); end
      default: begin mul_a = br_q; mul_b = 17'(wr_q); end
    endcase
  end

  always_comb begin
    vr    = 35'((acc_re_q + 50'sd16384) >>> 15);
    vi    = 35'((acc_im_q + 50'sd16384) >>> 15);
    yp_re = scale_out(r2fft_pkg::sat32(36'(ur_q) + 36'(vr)), lg, inv_q && last_stage);
    yp_im = scale_out(r2fft_pkg::sat32(36'(ui_q) + 36'(vi)), lg, inv_q && last_stage);
    yq_re = scale_out(r2fft_pkg::sat32(36'(ur_q) - 36'(vr)), lg, inv_q && last_stage);
    yq_im = scale_out(r2fft_pkg::sat32(36'(ui_q) - 36'(vi)), lg, inv_q && last_stage);
  end

  always_comb begin
    state_d   = state_q;
    log2_d    = log2_q;
    inv_d     = inv_q;
    count_d   = count_q;
    done_d    = done_q;
    stage_d   = stage_q;
    bfly_d    = bfly_q;
    mstep_d   = mstep_q;
    rd_ok_d   = rd_ok_q;
    ram_we    = 1'b0;
    ram_waddr = load_addr;
    ram_wdata = {32'(cmd_i.sample_re), 32'(cmd_i.sample_im)};
    ram_raddr = p_addr;

    unique case (state_q)
      r2fft_pkg::S_IDLE: begin
        if (cfg_take) begin
          case (r2fft_pkg::cfg_reg_e'(cfg_index_i))
            r2fft_pkg::CFG_LOG2_POINTS: begin
              log2_d  = cfg_data_i;
              count_d = '0;
              done_d  = 1'b0;
            end
            r2fft_pkg::CFG_INVERSE_MODE: begin
              inv_d   = cfg_data_i[0];
              count_d = '0;
              done_d  = 1'b0;
            end
            default: ;
          endcase
        end else if (cmd_take) begin
          if (cmd_i.func == r2fft_pkg::FUNC_READ) begin
            ram_raddr = AW'(cmd_i.bin_index);
            rd_ok_d   = done_q && ((AW + 1)'(cmd_i.bin_index) < npts_cur);
            state_d   = r2fft_pkg::S_READ;
          end else begin
            ram_we = 1'b1;
            if (done_q) begin
              ram_waddr = '0;
              count_d   = (AW + 1)'(1);
              done_d    = 1'b0;
            end else begin
              count_d = count_q + (AW + 1)'(1);
            end
            if (count_d == npts_cur) begin
              count_d = '0;
              stage_d = LG_W'(1);
              bfly_d  = '0;
              state_d = r2fft_pkg::S_RD_P;
            end
          end
        end
      end
      r2fft_pkg::S_READ: begin
        state_d = r2fft_pkg::S_IDLE;
      end
      r2fft_pkg::S_RD_P: begin
        ram_raddr = p_addr;
        state_d   = r2fft_pkg::S_RD_Q;
      end
      r2fft_pkg::S_RD_Q: begin
        ram_raddr = q_addr;
        state_d   = r2fft_pkg::S_GET_B;
      end
      r2fft_pkg::S_GET_B: begin
        mstep_d = '0;
        state_d = r2fft_pkg::S_MUL;
      end
      r2fft_pkg::S_MUL: begin
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == 3'd4) begin
          state_d = r2fft_pkg::S_WR_P;
        end
      end
      r2fft_pkg::S_WR_P: begin
        ram_we    = 1'b1;
        ram_waddr = p_addr;
        ram_wdata = {yp_re, yp_im};
        state_d   = r2fft_pkg::S_WR_Q;
      end
      r2fft_pkg::S_WR_Q: begin
        ram_we    = 1'b1;
        ram_waddr = q_addr;
        ram_wdata = {yq_re, yq_im};
        state_d   = r2fft_pkg::S_RD_P;
        if (last_bfly) begin
          bfly_d = '0;
          if (last_stage) begin
            done_d  = 1'b1;
            state_d = r2fft_pkg::S_IDLE;
          end else begin
            stage_d = stage_q + LG_W'(1);
          end
        end else begin
          bfly_d = bfly_q + AW'(1);
        end
      end
      default: state_d = r2fft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= r2fft_pkg::S_IDLE;
      log2_q         <= 4'd10;
      inv_q          <= 1'b0;
      count_q        <= '0;
      done_q         <= 1'b0;
      stage_q        <= LG_W'(1);
      bfly_q         <= '0;
      mstep_q        <= '0;
      rd_ok_q        <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      log2_q         <= log2_d;
      inv_q          <= inv_d;
      count_q        <= count_d;
      done_q         <= done_d;
      stage_q        <= stage_d;
      bfly_q         <= bfly_d;
      mstep_q        <= mstep_d;
      rd_ok_q        <= rd_ok_d;
      result_valid_q <= (state_q == r2fft_pkg::S_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == r2fft_pkg::S_READ) begin
      result_q.bin_re    <= rd_ok_q ? ram_rdata[63:32] : '0;
      result_q.bin_im    <= rd_ok_q ? ram_rdata[31:0] : '0;
      result_q.bin_valid <= rd_ok_q;
    end
    if (state_q == r2fft_pkg::S_RD_Q) begin
      ur_q <= ram_rdata[63:32];
      ui_q <= ram_rdata[31:0];
    end
    if (state_q == r2fft_pkg::S_GET_B) begin
      br_q <= ram_rdata[63:32];
      bi_q <= ram_rdata[31:0];
      wr_q <= TW_COS[tw_idx];
      wi_q <= inv_q ? -17'(TW_SIN[tw_idx]) : 17'(TW_SIN[tw_idx]);
    end
    if (state_q == r2fft_pkg::S_MUL) begin
      prod_q <= mul_a * mul_b;
      unique case (mstep_q)
        3'd1:    acc_re_q <= 50'(prod_q);
        3'd2:    acc_re_q <= acc_re_q - 50'(prod_q);
        3'd3:    acc_im_q <= 50'(prod_q);
        3'd4:    acc_im_q <= acc_im_q + 50'(prod_q);
        default: ;
      endcase
    end
  end

  r2fft_ram #(
    .WIDTH(64),
    .DEPTH(NPTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `R2FFT_ASSERT_NEXT(a_read_strobe, state_q == r2fft_pkg::S_READ, result_valid_o)
  `R2FFT_ASSERT_IMP(a_valid_needs_frame, result_valid_o && result_o.bin_valid, done_q)
  `R2FFT_ASSERT_NEXT(a_frame_end, state_q == r2fft_pkg::S_WR_Q && last_bfly && last_stage, done_q && !busy)

endmodule
